[rtl/core/swpe_pkg.sv]
// ----------------------------------------------------------------------------
// swpe_pkg
// Shared types and constants of the sliding window patch extractor.
// ----------------------------------------------------------------------------
package swpe_pkg;

  localparam int PIX_W     = 8;   // pixel width
  localparam int DIM_W     = 13;  // image_width / image_height register width
  localparam int TILE_W    = 4;   // tile_size register width
  localparam int CNT_W     = 12;  // row and column counters
  localparam int SLOT_W    = 3;   // row store slot index, covers up to 8 rows
  localparam int PEND_W    = 3;   // windows queued or in progress
  localparam int CMD_DEPTH = 4;   // window command queue
  localparam int OUT_DEPTH = 4;   // result queue
  localparam int OCNT_W    = 3;   // result queue fill count
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE_SIZE    = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [TILE_W-1:0] tile_size;
  } cfg_t;

  // row store write from the front
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  col;
    logic [PIX_W-1:0]  data;
  } wr_t;

  // one window to read out: top row slot, left column, side length
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  col;
    logic [TILE_W-1:0] tile;
  } cmd_t;

  typedef struct packed {
    logic win_done;  // last read of a window issued
  } back_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

endpackage

[rtl/core/swpe_fifo.sv]
// ----------------------------------------------------------------------------
// swpe_fifo
// Small register queue used for window commands and for results.
// ----------------------------------------------------------------------------
module swpe_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [DATA_W-1:0]          data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [DATA_W-1:0]          data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/swpe_front.sv]
// ----------------------------------------------------------------------------
// swpe_front
// Accepts pixels, writes them to the row store, tracks row and column,
// and queues a read-out command for each pixel that completes a window.
// ----------------------------------------------------------------------------
module swpe_front #(
  parameter int MAX_TILE  = 8,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swpe_pkg::cfg_t            cfg_i,
  input  logic                      push_i,
  input  logic [swpe_pkg::PIX_W-1:0] pixel_i,
  output logic                      full_o,
  output swpe_pkg::wr_t             wr_o,
  output swpe_pkg::cmd_t            cmd_o,
  output logic                      cmd_push_o,
  input  logic                      cmd_full_i,
  input  swpe_pkg::back_stat_t      stat_i
);

  import swpe_pkg::*;

  localparam int WLimInt = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam logic [DIM_W-1:0]  WLim = DIM_W'(WLimInt);
  localparam logic [TILE_W-1:0] TLim = TILE_W'(MAX_TILE);
  localparam int SlotSumW = SLOT_W + 2;

  logic [CNT_W-1:0]  col_q, col_d, row_q, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              phase_q, phase_d, win_phase_q, win_phase_d;
  logic [PEND_W-1:0] pend_q, pend_d;

  logic [DIM_W-1:0]    w, h, t_ext, col_p1, row_p1, c0_full;
  logic [TILE_W-1:0]   t;
  logic [SlotSumW-1:0] slot_sum;
  logic [SLOT_W-1:0]   top_slot;
  logic                is_win, hazard, accept;

  // effective register values
  always_comb begin
    if (cfg_i.image_width == '0) begin
      w = DIM_W'(1);
    end else if (cfg_i.image_width > WLim) begin
      w = WLim;
    end else begin
      w = cfg_i.image_width;
    end
    if (cfg_i.image_height == '0) begin
      h = DIM_W'(1);
    end else if (cfg_i.image_height > DIM_LIMIT) begin
      h = DIM_LIMIT;
    end else begin
      h = cfg_i.image_height;
    end
    if (cfg_i.tile_size == '0) begin
      t = TILE_W'(1);
    end else if (cfg_i.tile_size > TLim) begin
      t = TLim;
    end else begin
      t = cfg_i.tile_size;
    end
  end

  assign t_ext  = DIM_W'(t);
  assign col_p1 = DIM_W'(col_q) + DIM_W'(1);
  assign row_p1 = DIM_W'(row_q) + DIM_W'(1);
  assign is_win = (t_ext <= w) && (t_ext <= h) && (col_p1 >= t_ext) && (row_p1 >= t_ext);

  // A new row may overwrite rows an outstanding window still reads; wait for
  // the back to drain before the first write of a new row.
  assign hazard = (pend_q != '0) && (phase_q != win_phase_q);
  assign full_o = hazard || (is_win && cmd_full_i);
  assign accept = push_i && !full_o;

  // top row slot = (row - (t-1)) mod MAX_TILE
  assign slot_sum = SlotSumW'(slot_q) + SlotSumW'(MAX_TILE) + SlotSumW'(1) - SlotSumW'(t);
  assign top_slot = (slot_sum >= SlotSumW'(MAX_TILE)) ?
                    SLOT_W'(slot_sum - SlotSumW'(MAX_TILE)) : SLOT_W'(slot_sum);
  assign c0_full  = col_p1 - t_ext;

  always_comb begin
    wr_o.en   = accept;
    wr_o.slot = slot_q;
    wr_o.col  = col_q;
    wr_o.data = pixel_i;
    cmd_o.slot = top_slot;
    cmd_o.col  = c0_full[CNT_W-1:0];
    cmd_o.tile = t;
    cmd_push_o = accept && is_win;
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    slot_d      = slot_q;
    phase_d     = phase_q;
    win_phase_d = cmd_push_o ? phase_q : win_phase_q;
    pend_d      = pend_q + PEND_W'(cmd_push_o) - PEND_W'(stat_i.win_done);
    if (accept) begin
      if (col_p1 >= w) begin
        col_d   = '0;
        phase_d = !phase_q;
        if (row_p1 >= h) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_p1[CNT_W-1:0];
          slot_d = (slot_q == SLOT_W'(MAX_TILE - 1)) ? '0 : slot_q + 1'b1;
        end
      end else begin
        col_d = col_p1[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      phase_q     <= 1'b0;
      win_phase_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      slot_q      <= slot_d;
      phase_q     <= phase_d;
      win_phase_q <= win_phase_d;
      pend_q      <= pend_d;
    end
  end

endmodule

[rtl/core/swpe_back.sv]
// ----------------------------------------------------------------------------
// swpe_back
// Holds the row store and reads each queued window out row-major into the
// result queue, one pixel per cycle while that queue has room.
// ----------------------------------------------------------------------------
module swpe_back #(
  parameter int MAX_TILE  = 8,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swpe_pkg::wr_t               wr_i,
  input  swpe_pkg::cmd_t              cmd_i,
  input  logic                        cmd_empty_i,
  output logic                        cmd_pop_o,
  output swpe_pkg::back_stat_t        stat_o,
  input  logic [swpe_pkg::OCNT_W-1:0] out_count_i,
  output logic                        out_push_o,
  output logic [swpe_pkg::PIX_W-1:0]  out_pixel_o,
  output logic                        out_last_o
);

  import swpe_pkg::*;

  localparam int Depth = MAX_TILE * MAX_WIDTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [PIX_W-1:0] mem_q [Depth];

  back_state_e       state_q, state_d;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  col_q, c0_q;
  logic [TILE_W-1:0] i_q, j_q, tile_q, tile_m1;
  logic              rd_valid_q, rd_last_q;
  logic [PIX_W-1:0]  rd_data_q;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              room, issue, last;

  assign wr_addr = AW'(32'(wr_i.slot) * MAX_WIDTH + 32'(wr_i.col));
  assign rd_addr = AW'(32'(slot_q) * MAX_WIDTH + 32'(col_q));

  assign tile_m1 = tile_q - 1'b1;
  assign last    = (i_q == tile_m1) && (j_q == tile_m1);
  // count the read in flight so the result queue never overflows
  assign room    = (out_count_i + OCNT_W'(rd_valid_q)) < OCNT_W'(OUT_DEPTH);
  assign issue   = (state_q == BK_RUN) && room;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue && last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o       = (state_q == BK_IDLE) && !cmd_empty_i;
    stat_o.win_done = issue && last;
    out_push_o      = rd_valid_q;
    out_pixel_o     = rd_data_q;
    out_last_o      = rd_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
    end
  end

  // window walk
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      slot_q <= cmd_i.slot;
      col_q  <= cmd_i.col;
      c0_q   <= cmd_i.col;
      tile_q <= cmd_i.tile;
      i_q    <= '0;
      j_q    <= '0;
    end else if (issue) begin
      if (j_q == tile_m1) begin
        j_q    <= '0;
        col_q  <= c0_q;
        i_q    <= i_q + 1'b1;
        slot_q <= (slot_q == SLOT_W'(MAX_TILE - 1)) ? '0 : slot_q + 1'b1;
      end else begin
        j_q   <= j_q + 1'b1;
        col_q <= col_q + 1'b1;
      end
    end
  end

  // row store
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.data;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_addr];
      rd_last_q <= last;
    end
  end

endmodule

[rtl/core/sliding_window_patch_extractor_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_patch_extractor_top
// Im2col patch extractor: emits every full tile_size square window of a
// raster-order grayscale frame once its bottom-right pixel arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on pixel_i with push/full, one per transfer, in raster order.
//   Window pixels leave row-major on patch_pixel_o/patch_last_o with
//   empty/pop; patch_last_o marks the final pixel of each window.
//   Registers (APB, byte address 4*i): image_width, image_height, tile_size.
//   A window of side t is read out as t*t row store reads, one per cycle
//   while the result queue has room. Its first pixel goes from the command
//   queue through the read-out idle state and the row store read register
//   into the result queue. Up to 4 windows queue between front and back, so
//   pixels within a row keep flowing while earlier windows drain; the first
//   pixel of a new row waits until all pending windows are read out.
//   Reset clears the counters, queues and registers (64, 64, 3); the row
//   store is not cleared. When pop is held low, the result queue fills, the
//   read-out pauses, then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module sliding_window_patch_extractor_top #(
  parameter int MAX_TILE  = 8,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel input
  input  logic                         push,
  output logic                         full,
  input  logic [swpe_pkg::PIX_W-1:0]   pixel_i,
  // window output
  output logic                         empty,
  input  logic                         pop,
  output logic [swpe_pkg::PIX_W-1:0]   patch_pixel_o,
  output logic                         patch_last_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swpe_pkg::APB_AW-1:0]  paddr,
  input  logic [swpe_pkg::APB_DW-1:0]  pwdata,
  output logic [swpe_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  import swpe_pkg::*;

  localparam int CmdW = $bits(cmd_t);
  localparam int OutW = PIX_W + 1;

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;

  wr_t        wr;
  cmd_t       cmd_in, cmd_out;
  logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
  back_stat_t stat;

  logic              out_push, out_last;
  logic [PIX_W-1:0]  out_pixel;
  logic [OCNT_W-1:0] out_count;
  logic [OutW-1:0]   out_head;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IMAGE_WIDTH:  cfg_d.image_width  = pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = pwdata[DIM_W-1:0];
        REG_TILE_SIZE:    cfg_d.tile_size    = pwdata[TILE_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= DIM_W'(64);
      cfg_q.image_height <= DIM_W'(64);
      cfg_q.tile_size    <= TILE_W'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_q.image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_q.image_height);
      REG_TILE_SIZE:    prdata = APB_DW'(cfg_q.tile_size);
      default:          prdata = '0;
    endcase
  end

  swpe_front #(
    .MAX_TILE  (MAX_TILE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .pixel_i    (pixel_i),
    .full_o     (full),
    .wr_o       (wr),
    .cmd_o      (cmd_in),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full),
    .stat_i     (stat)
  );

  swpe_fifo #(
    .DATA_W (CmdW),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty),
    .count_o ()
  );

  swpe_back #(
    .MAX_TILE  (MAX_TILE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .stat_o      (stat),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_pixel_o (out_pixel),
    .out_last_o  (out_last)
  );

  swpe_fifo #(
    .DATA_W (OutW),
    .DEPTH  (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  ({out_pixel, out_last}),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_head),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign patch_pixel_o = out_head[OutW-1:1];
  assign patch_last_o  = out_head[0];

endmodule

[rtl/core/swpe_checker.sv]
// ----------------------------------------------------------------------------
// swpe_checker
// Port-level checks of the patch extractor, bound to the top level.
// ----------------------------------------------------------------------------
module swpe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [swpe_pkg::PIX_W-1:0]  patch_pixel_o,
  input logic                        patch_last_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [swpe_pkg::APB_AW-1:0] paddr,
  input logic [swpe_pkg::APB_DW-1:0] pwdata,
  input logic [swpe_pkg::APB_DW-1:0] prdata,
  input logic                        pready
);

  import swpe_pkg::*;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;

  // no result is waiting in the cycle after a reset cycle
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // a waiting result holds while pop is low
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(patch_pixel_o) && $stable(patch_last_o)))
    else $error("waiting result changed without a transfer");

  // a written image_width reads back
  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[3:2] == REG_IMAGE_WIDTH) |=>
      (paddr != $past(paddr)) || (prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0])))
    else $error("image_width readback mismatch");

  // a written tile_size reads back
  a_tile_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[3:2] == REG_TILE_SIZE) |=>
      (paddr != $past(paddr)) || (prdata[TILE_W-1:0] == $past(pwdata[TILE_W-1:0])))
    else $error("tile_size readback mismatch");

endmodule

bind sliding_window_patch_extractor_top swpe_checker u_swpe_checker (.*);

[tb/patch_stream_checker.sv]
// ----------------------------------------------------------------------------
// patch_stream_checker
// Watches the pixel, window and register channels of the patch extractor.
// Keeps its own copy of the row store, counters and registers, expands each
// pixel transfer into the window pixels it completes, and compares every
// result transfer with the oldest of those.
// ----------------------------------------------------------------------------
module patch_stream_checker #(
  parameter int MAX_TILE  = 8,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [swpe_pkg::PIX_W-1:0]   pixel_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic [swpe_pkg::PIX_W-1:0]   patch_pixel_i,
  input  logic                         patch_last_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [swpe_pkg::APB_AW-1:0]  paddr_i,
  input  logic [swpe_pkg::APB_DW-1:0]  pwdata_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import swpe_pkg::*;

  localparam int unsigned COUNT_MAX = 4096;
  localparam int unsigned WIDTH_MAX = (MAX_WIDTH < COUNT_MAX) ? MAX_WIDTH : COUNT_MAX;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } patch_px_t;

  patch_px_t         window_px_q[$];
  logic [PIX_W-1:0]  row_mem [MAX_TILE*MAX_WIDTH];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [TILE_W-1:0] tile_reg;
  int unsigned       col_cnt;
  int unsigned       row_cnt;
  int unsigned       fails;
  int unsigned       w_eff;
  int unsigned       h_eff;
  int unsigned       t_eff;
  int unsigned       top_row;
  int unsigned       left_col;
  patch_px_t         got;
  patch_px_t         want;

  // zero acts as one, oversized values saturate
  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned mem_addr(int unsigned r, int unsigned c);
    return (r % MAX_TILE) * MAX_WIDTH + (c % MAX_WIDTH);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_px_q.delete();
      width_reg    = 13'd64;
      height_reg   = 13'd64;
      tile_reg     = 4'd3;
      col_cnt      = 0;
      row_cnt      = 0;
      fails        = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // result transfer
      if (pop_i && !empty_i) begin
        got = '{pix: patch_pixel_i, last: patch_last_i};
        if (window_px_q.size() == 0) begin
          fails++;
          $error("patch_pixel: transfer of %0d with no window pixel pending", got.pix);
        end else begin
          want = window_px_q.pop_front();
          if (got.pix !== want.pix) begin
            fails++;
            $error("patch_pixel: expected %0d, got %0d", want.pix, got.pix);
          end
          if (got.last !== want.last) begin
            fails++;
            $error("patch_last: expected %0d, got %0d", want.last, got.last);
          end
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_AW-1:2])
          REG_IMAGE_WIDTH:  width_reg  = pwdata_i[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = pwdata_i[DIM_W-1:0];
          REG_TILE_SIZE:    tile_reg   = pwdata_i[TILE_W-1:0];
          default: ;
        endcase
      end

      // pixel transfer: store it, then emit the window it completes
      if (push_i && !full_i) begin
        w_eff = clip(width_reg, WIDTH_MAX);
        h_eff = clip(height_reg, COUNT_MAX);
        t_eff = clip(tile_reg, MAX_TILE);
        row_mem[mem_addr(row_cnt, col_cnt)] = pixel_i;
        if (t_eff <= w_eff && t_eff <= h_eff && col_cnt + 1 >= t_eff &&
            row_cnt + 1 >= t_eff) begin
          top_row  = row_cnt + 1 - t_eff;
          left_col = col_cnt + 1 - t_eff;
          for (int i = 0; i < t_eff; i++) begin
            for (int j = 0; j < t_eff; j++) begin
              window_px_q.push_back('{pix:  row_mem[mem_addr(top_row + i, left_col + j)],
                                      last: (i == t_eff - 1 && j == t_eff - 1)});
            end
          end
        end
        // a counter at or past a lowered limit wraps on this pixel
        if (col_cnt + 1 >= w_eff) begin
          col_cnt = 0;
          row_cnt = (row_cnt + 1 >= h_eff) ? 0 : row_cnt + 1;
        end else begin
          col_cnt++;
        end
      end

      pending_o    <= window_px_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

[tb/sliding_window_patch_extractor_top_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_patch_extractor_top_test
// Drives random pixels through the patch extractor under a range of image
// and tile geometries: degenerate and saturating register values, tiles that
// do not fit, a mid-frame height change, and whole frames of random small
// geometries with random stalls on both sides. The checker does the scoring.
// ----------------------------------------------------------------------------
module sliding_window_patch_extractor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swpe_pkg::*;

  localparam int MAX_TILE    = 8;
  localparam int MAX_WIDTH   = 4096;
  localparam int RAND_ITEMS  = 190;
  localparam int SETTLE      = 12;         // read-out may still be finishing
  localparam int TAIL        = 80;         // longest window plus latency
  localparam int CYCLE_LIMIT = 2_000_000;  // slowest legal run is well under half

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               push    = 1'b0;
  logic               full;
  logic [PIX_W-1:0]   pixel_i = '0;
  logic               empty;
  logic               pop     = 1'b0;
  logic [PIX_W-1:0]   patch_pixel_o;
  logic               patch_last_o;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [APB_AW-1:0]  paddr   = '0;
  logic [APB_DW-1:0]  pwdata  = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int  pending;
  int  fail_count;
  int  cycle_cnt   = 0;
  int  pop_gap     = 0;
  int  rand_pixels = 0;
  bit  idle_on     = 1'b1;
  bit  paused      = 1'b0;

  sliding_window_patch_extractor_top #(
    .MAX_TILE (MAX_TILE),
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_i      (pixel_i),
    .empty        (empty),
    .pop          (pop),
    .patch_pixel_o(patch_pixel_o),
    .patch_last_o (patch_last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  patch_stream_checker #(
    .MAX_TILE (MAX_TILE),
    .MAX_WIDTH(MAX_WIDTH)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .pixel_i      (pixel_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .patch_pixel_i(patch_pixel_o),
    .patch_last_i (patch_last_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (pop_gap > 0) begin
      pop     <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop     <= 1'b0;
      pop_gap <= $urandom_range(0, 5);
    end else begin
      pop <= 1'b1;
    end
  end

  // upper pwdata bits are don't-care, so they get random junk half the time
  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] value);
    logic [APB_DW-1:0] junk;
    junk    = $urandom_range(0, 1) ? ($urandom << DIM_W) : '0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= junk | APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [DIM_W-1:0] t);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_TILE_SIZE, t);
  endtask

  // returns in the step of the transfer
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push    <= 1'b1;
    pixel_i <= value;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_burst(input int n);
    for (int k = 0; k < n; k++) send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // whole frames of a random small geometry; register values of zero and
  // oversized tiles show up now and then
  task automatic random_phase();
    int unsigned t_reg;
    int unsigned t_eff;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned w_reg;
    int unsigned h_reg;
    int          total;
    case ($urandom_range(0, 9))
      0:       t_reg = 0;
      1:       t_reg = $urandom_range(9, 15);
      default: t_reg = $urandom_range(1, 8);
    endcase
    t_eff = (t_reg == 0) ? 1 : ((t_reg > 8) ? 8 : t_reg);
    if (t_eff > 1 && $urandom_range(0, 7) == 0) w_eff = $urandom_range(1, t_eff - 1);
    else w_eff = $urandom_range(t_eff, t_eff + 3);
    if (t_eff > 1 && $urandom_range(0, 7) == 0) h_eff = $urandom_range(1, t_eff - 1);
    else h_eff = $urandom_range(t_eff, t_eff + 2);
    w_reg = (w_eff == 1 && $urandom_range(0, 1)) ? 0 : w_eff;
    h_reg = (h_eff == 1 && $urandom_range(0, 1)) ? 0 : h_eff;
    total = w_eff * h_eff * $urandom_range(1, 2);

    drain();
    set_geometry(DIM_W'(w_reg), DIM_W'(h_reg), DIM_W'(t_reg));
    // last stretch of the run has no idling
    idle_on <= (rand_pixels < RAND_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
    for (int k = 0; k < total; k++) begin
      if (!paused && k == total / 2 && k > 0) begin
        drain();
        paused = 1'b1;
      end
      send_pixel(PIX_W'($urandom_range(0, 255)));
      rand_pixels++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero registers act as 1: every pixel is its own window
    set_geometry(13'd0, 13'd0, 13'd0);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    send_pixel(8'hAA);

    // tile wider than the image, then taller: no windows at all
    drain();
    set_geometry(13'd2, 13'd3, 13'd3);
    send_burst(6);
    drain();
    set_geometry(13'd3, 13'd2, 13'd3);
    send_burst(6);

    // width saturates to 4096: no column wrap within the first row
    drain();
    set_geometry(13'h1FFF, 13'd2, 13'd2);
    send_burst(8);

    // height saturates to 4096: the leftover column wraps on the first
    // pixel, then rows count on past the row store's slots
    drain();
    set_geometry(13'd2, 13'h1FFF, 13'd2);
    send_burst(21);

    // lowering the height mid-frame: row counter wraps after this row
    drain();
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    send_burst(2);

    while (rand_pixels < RAND_ITEMS) random_phase();

    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/swpe_pkg.sv
rtl/core/swpe_fifo.sv
rtl/core/swpe_front.sv
rtl/core/swpe_back.sv
rtl/core/sliding_window_patch_extractor_top.sv
rtl/core/swpe_checker.sv
tb/patch_stream_checker.sv
tb/sliding_window_patch_extractor_top_test.sv
